>>> rtl/core/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared sizes, command encoding and queue types for the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  // Tree sizing
  localparam int MAX_LEAVES    = 16;
  localparam int NODE_CNT      = 2 * MAX_LEAVES - 1;
  localparam int NODE_W        = $clog2(NODE_CNT);
  localparam int LEAF_CNT_W    = $clog2(MAX_LEAVES + 1);

  // Field widths
  localparam int WEIGHT_W      = 16;
  localparam int NODE_WEIGHT_W = 20;
  localparam int LEAF_IDX_W    = 4;
  localparam int CODE_W        = 15;
  localparam int LEN_W         = 4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_LEAF  = 2'b01,
    CMD_BUILD = 2'b10
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

>>> rtl/core/huffman_code_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol weights, builds a Huffman tree and emits one code per leaf.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Handshake
// input     in_weight, in_last_weight                    start && !busy
// result    out_leaf_index, out_code_bits,               out_valid, one cycle
//           out_code_length, out_last_code
//
// Weight transactions are popped from the four-entry queue into the node store.
// A build over M leaves runs a serial scan of the node store
// (one node per cycle, one scan per merge); each leaf's code walk then climbs
// from the leaf to the root. busy rises only when the queue is full.
// Reset is synchronous; the result port cannot be stalled.
// ----------------------------------------------------------------------------
module huffman_code_builder
  import hcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [WEIGHT_W-1:0]   in_weight,
  input  logic                  in_last_weight,
  output logic                  out_valid,
  output logic [LEAF_IDX_W-1:0] out_leaf_index,
  output logic [CODE_W-1:0]     out_code_bits,
  output logic [LEN_W-1:0]      out_code_length,
  output logic                  out_last_code
);

  queue_head_t head;
  logic        pop;

  hcb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_weight      (in_weight),
    .in_last_weight (in_last_weight),
    .head           (head),
    .pop            (pop)
  );

  hcb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_leaf_index  (out_leaf_index),
    .out_code_bits   (out_code_bits),
    .out_code_length (out_code_length),
    .out_last_code   (out_last_code)
  );

  // Two results never leave in adjacent cycles: each leaf needs a code walk
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results emitted in adjacent cycles");

  // An empty code only comes from a single-leaf tree
  a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_length == '0) |-> (out_last_code && out_leaf_index == '0))
    else $error("zero-length code on a multi-leaf tree");

  // No code bits above the code length
  a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_code_bits >> out_code_length) == '0))
    else $error("code bits set above code length");

  // Queue never pops when empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

endmodule

>>> rtl/core/hcb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_front
// Accepts weight transactions, tags them as leaf or build commands and holds
// them in a small queue for the tree builder.
// ----------------------------------------------------------------------------
module hcb_front
  import hcb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                in_last_weight,
  output queue_head_t         head,
  input  logic                pop
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push;
  cmd_t              new_cmd;

  // Classify the incoming transaction
  always_comb begin
    new_cmd.weight = in_weight;
    new_cmd.kind   = in_last_weight ? CMD_BUILD : CMD_LEAF;
  end

  assign busy       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

>>> rtl/core/hcb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_back
// Loads leaf weights, builds the tree by serial two-smallest scans and walks
// each leaf up to the root to emit its code.
// ----------------------------------------------------------------------------
module hcb_back
  import hcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  queue_head_t           head,
  output logic                  pop,
  output logic                  out_valid,
  output logic [LEAF_IDX_W-1:0] out_leaf_index,
  output logic [CODE_W-1:0]     out_code_bits,
  output logic [LEN_W-1:0]      out_code_length,
  output logic                  out_last_code
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_MERGE  = 5'b00100,
    ST_WALK_P = 5'b01000,
    ST_WALK_L = 5'b10000
  } back_state_t;

  // Node store
  logic [NODE_WEIGHT_W-1:0] weight_r     [NODE_CNT];
  logic [NODE_W-1:0]        parent_r     [NODE_CNT];
  logic [NODE_W-1:0]        left_r       [NODE_CNT];
  logic [NODE_CNT-1:0]      has_parent_r;

  back_state_t              state_r, state_nxt;
  logic [LEAF_CNT_W-1:0]    leaf_cnt_r, leaf_cnt_nxt;
  logic [LEAF_CNT_W-1:0]    m_r, m_nxt;
  logic [NODE_W-1:0]        n_r, n_nxt;
  logic [NODE_W-1:0]        scan_r, scan_nxt;
  logic [NODE_W-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [NODE_WEIGHT_W-1:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic                     a_found_r, a_found_nxt, b_found_r, b_found_nxt;
  logic [LEAF_CNT_W-1:0]    leaf_r, leaf_nxt;
  logic [NODE_W-1:0]        c_r, c_nxt, f_r, f_nxt;
  logic [NODE_W-1:0]        len_r, len_nxt;
  logic [CODE_W-1:0]        code_r, code_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [LEAF_IDX_W-1:0]    out_leaf_r, out_leaf_nxt;
  logic [CODE_W-1:0]        out_code_r, out_code_nxt;
  logic [LEN_W-1:0]         out_len_r, out_len_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     load_we;
  logic [NODE_W-1:0]        load_addr;
  logic                     merge_we;
  logic                     hp_clear;
  logic [LEAF_CNT_W-1:0]    cnt_after;
  logic [NODE_WEIGHT_W-1:0] scan_w;
  logic [NODE_WEIGHT_W:0]   sum_full;
  logic [NODE_WEIGHT_W-1:0] sum_sat;
  logic [LEAF_CNT_W-1:0]    leaf_inc;

  assign scan_w   = weight_r[scan_r];
  assign sum_full = {1'b0, wa_r} + {1'b0, wb_r};
  assign sum_sat  = sum_full[NODE_WEIGHT_W] ? '1 : sum_full[NODE_WEIGHT_W-1:0];
  assign leaf_inc = leaf_r + 1'b1;

  // Sequence load, scan, merge and code walk
  always_comb begin
    state_nxt     = state_r;
    leaf_cnt_nxt  = leaf_cnt_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    scan_nxt      = scan_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    a_found_nxt   = a_found_r;
    b_found_nxt   = b_found_r;
    leaf_nxt      = leaf_r;
    c_nxt         = c_r;
    f_nxt         = f_r;
    len_nxt       = len_r;
    code_nxt      = code_r;
    out_valid_nxt = 1'b0;
    out_leaf_nxt  = out_leaf_r;
    out_code_nxt  = out_code_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    load_we       = 1'b0;
    load_addr     = NODE_W'(leaf_cnt_r);
    merge_we      = 1'b0;
    hp_clear      = 1'b0;
    cnt_after     = leaf_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          // Drop weights past the leaf capacity
          if (leaf_cnt_r < LEAF_CNT_W'(MAX_LEAVES)) begin
            load_we   = 1'b1;
            cnt_after = leaf_cnt_r + 1'b1;
          end
          leaf_cnt_nxt = cnt_after;
          if (head.cmd.kind == CMD_BUILD) begin
            hp_clear    = 1'b1;
            m_nxt       = cnt_after;
            n_nxt       = NODE_W'(cnt_after);
            scan_nxt    = '0;
            a_found_nxt = 1'b0;
            b_found_nxt = 1'b0;
            leaf_nxt    = '0;
            c_nxt       = '0;
            len_nxt     = '0;
            code_nxt    = '0;
            state_nxt   = (cnt_after == LEAF_CNT_W'(1)) ? ST_WALK_P : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Track the two smallest parentless nodes, lowest index on ties
        if (!has_parent_r[scan_r]) begin
          if (!a_found_r || scan_w < wa_r) begin
            b_nxt       = a_r;
            wb_nxt      = wa_r;
            b_found_nxt = a_found_r;
            a_nxt       = scan_r;
            wa_nxt      = scan_w;
            a_found_nxt = 1'b1;
          end else if (!b_found_r || scan_w < wb_r) begin
            b_nxt       = scan_r;
            wb_nxt      = scan_w;
            b_found_nxt = 1'b1;
          end
        end
        if (scan_r == n_r - 1'b1) begin
          state_nxt = ST_MERGE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      ST_MERGE: begin
        merge_we    = 1'b1;
        n_nxt       = n_r + 1'b1;
        scan_nxt    = '0;
        a_found_nxt = 1'b0;
        b_found_nxt = 1'b0;
        // Root made once 2M-1 nodes exist
        if ((NODE_W+1)'(n_r) + (NODE_W+1)'(2) == (NODE_W+1)'({m_r, 1'b0})) begin
          leaf_nxt  = '0;
          c_nxt     = '0;
          len_nxt   = '0;
          code_nxt  = '0;
          state_nxt = ST_WALK_P;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_WALK_P: begin
        if (has_parent_r[c_r]) begin
          f_nxt     = parent_r[c_r];
          state_nxt = ST_WALK_L;
        end else begin
          // Reached the root: emit this leaf's code
          out_valid_nxt = 1'b1;
          out_leaf_nxt  = LEAF_IDX_W'(leaf_r);
          out_code_nxt  = code_r;
          out_len_nxt   = LEN_W'(len_r);
          out_last_nxt  = (leaf_inc == m_r);
          if (leaf_inc == m_r) begin
            leaf_cnt_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            leaf_nxt = leaf_inc;
            c_nxt    = NODE_W'(leaf_inc);
            len_nxt  = '0;
            code_nxt = '0;
          end
        end
      end

      ST_WALK_L: begin
        // Right branch gives a one at the current depth
        if (left_r[f_r] != c_r) begin
          code_nxt = code_r | (CODE_W'(1) << len_r);
        end
        len_nxt   = len_r + 1'b1;
        c_nxt     = f_r;
        state_nxt = ST_WALK_P;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      leaf_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      has_parent_r <= '0;
    end else begin
      state_r     <= state_nxt;
      leaf_cnt_r  <= leaf_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (hp_clear) begin
        has_parent_r <= '0;
      end else if (merge_we) begin
        has_parent_r[a_r] <= 1'b1;
        has_parent_r[b_r] <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    scan_r     <= scan_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    a_found_r  <= a_found_nxt;
    b_found_r  <= b_found_nxt;
    leaf_r     <= leaf_nxt;
    c_r        <= c_nxt;
    f_r        <= f_nxt;
    len_r      <= len_nxt;
    code_r     <= code_nxt;
    out_leaf_r <= out_leaf_nxt;
    out_code_r <= out_code_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  // Node store writes
  always_ff @(posedge clk) begin
    if (load_we) begin
      weight_r[load_addr] <= NODE_WEIGHT_W'(head.cmd.weight);
    end else if (merge_we) begin
      weight_r[n_r] <= sum_sat;
    end
    if (merge_we) begin
      parent_r[a_r] <= n_r;
      parent_r[b_r] <= n_r;
      left_r[n_r]   <= a_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_leaf_index  = out_leaf_r;
  assign out_code_bits   = out_code_r;
  assign out_code_length = out_len_r;
  assign out_last_code   = out_valid_r && out_last_r;

endmodule
